@@ rtl/gbd_pkg.sv @@
package gbd_pkg;

    typedef enum logic [3:0] {
        CLS_CR      = 4'd0,
        CLS_LF      = 4'd1,
        CLS_CONTROL = 4'd2,
        CLS_EXTEND  = 4'd3,
        CLS_ZWJ     = 4'd4,
        CLS_RI      = 4'd5,
        CLS_PREPEND = 4'd6,
        CLS_SPACING = 4'd7,
        CLS_L       = 4'd8,
        CLS_V       = 4'd9,
        CLS_T       = 4'd10,
        CLS_LV      = 4'd11,
        CLS_LVT     = 4'd12,
        CLS_PICT    = 4'd13,
        CLS_OTHER   = 4'd14
    } t_break_class;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] CP_ZWJ         = 21'h0200D;
    localparam logic [CP_W-1:0] CP_HANGUL_LO   = 21'h0AC00;
    localparam logic [CP_W-1:0] CP_HANGUL_HI   = 21'h0D7A3;
    localparam logic [CP_W-1:0] CP_RI_LO       = 21'h1F1E6;
    localparam logic [CP_W-1:0] CP_RI_HI       = 21'h1F1FF;
    localparam logic [CP_W-1:0] CP_PICT_LO     = 21'h1F300;
    localparam logic [CP_W-1:0] CP_PICT_HI     = 21'h1F9FF;
    localparam logic [CP_W-1:0] CP_PICT2_LO    = 21'h02600;
    localparam logic [CP_W-1:0] CP_PICT2_HI    = 21'h027BF;
    localparam logic [CP_W-1:0] CP_COMB_LO     = 21'h00300;
    localparam logic [CP_W-1:0] CP_COMB_HI     = 21'h0036F;

endpackage

@@ rtl/gbd_classify.sv @@
module gbd_classify (
    input  logic [gbd_pkg::CP_W-1:0] i_code_point,
    output gbd_pkg::t_break_class    o_class
);

    function automatic logic in_span(
        input logic [gbd_pkg::CP_W-1:0] v,
        input logic [gbd_pkg::CP_W-1:0] lo,
        input logic [gbd_pkg::CP_W-1:0] hi
    );
        return (v >= lo) && (v <= hi);
    endfunction

    logic [gbd_pkg::CP_W-1:0] w_diff;
    logic [13:0]              w_off;
    logic [11:0]              w_quad;
    logic [4:0]               w_sum1;
    logic [3:0]               w_sum2;
    logic                     w_lv;

    // Syllable index mod 28: mod 4 from the low bits, mod 7 by folding octal digits.
    assign w_diff = i_code_point - gbd_pkg::CP_HANGUL_LO;
    assign w_off  = w_diff[13:0];
    assign w_quad = w_off[13:2];
    assign w_sum1 = {2'b00, w_quad[2:0]} + {2'b00, w_quad[5:3]}
                  + {2'b00, w_quad[8:6]} + {2'b00, w_quad[11:9]};
    assign w_sum2 = {1'b0, w_sum1[2:0]} + {2'b00, w_sum1[4:3]};
    assign w_lv   = (w_off[1:0] == 2'b00) && ((w_sum2 == 4'd0) || (w_sum2 == 4'd7));

    always_comb begin
        if (i_code_point == 21'h0000D) begin
            o_class = gbd_pkg::CLS_CR;
        end else if (i_code_point == 21'h0000A) begin
            o_class = gbd_pkg::CLS_LF;
        end else if ((i_code_point < 21'h00020) ||
                     in_span(i_code_point, 21'h0007F, 21'h0009F)) begin
            o_class = gbd_pkg::CLS_CONTROL;
        end else if (i_code_point == gbd_pkg::CP_ZWJ) begin
            o_class = gbd_pkg::CLS_ZWJ;
        end else if (in_span(i_code_point, gbd_pkg::CP_COMB_LO, gbd_pkg::CP_COMB_HI) ||
                     in_span(i_code_point, 21'h01AB0, 21'h01AFF) ||
                     in_span(i_code_point, 21'h01DC0, 21'h01DFF) ||
                     in_span(i_code_point, 21'h020D0, 21'h020FF) ||
                     in_span(i_code_point, 21'h0FE20, 21'h0FE2F)) begin
            o_class = gbd_pkg::CLS_EXTEND;
        end else if (in_span(i_code_point, gbd_pkg::CP_RI_LO, gbd_pkg::CP_RI_HI)) begin
            o_class = gbd_pkg::CLS_RI;
        end else if (in_span(i_code_point, 21'h01100, 21'h0115F)) begin
            o_class = gbd_pkg::CLS_L;
        end else if (in_span(i_code_point, 21'h01160, 21'h011A7)) begin
            o_class = gbd_pkg::CLS_V;
        end else if (in_span(i_code_point, 21'h011A8, 21'h011FF)) begin
            o_class = gbd_pkg::CLS_T;
        end else if (in_span(i_code_point, gbd_pkg::CP_HANGUL_LO, gbd_pkg::CP_HANGUL_HI)) begin
            o_class = w_lv ? gbd_pkg::CLS_LV : gbd_pkg::CLS_LVT;
        end else if (in_span(i_code_point, gbd_pkg::CP_PICT_LO, gbd_pkg::CP_PICT_HI) ||
                     in_span(i_code_point, gbd_pkg::CP_PICT2_LO, gbd_pkg::CP_PICT2_HI)) begin
            o_class = gbd_pkg::CLS_PICT;
        end else if (i_code_point == 21'h00903) begin
            o_class = gbd_pkg::CLS_SPACING;
        end else begin
            o_class = gbd_pkg::CLS_OTHER;
        end
    end

endmodule

@@ rtl/grapheme_boundary_detector.sv @@
// Grapheme cluster boundary detector.
// Input channel: i_valid / o_stall with i_code_point, i_text_begin and
// i_bad_sequence; an item is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with o_boundary and
// o_break_class, one result per input item, in order.
// Path: the accepting edge loads the input register, and the item moves on into
// the result register once that register is free; o_valid then rises, and the
// result leaves at an edge with i_stall low.
// Throughput: one item per cycle while the receiver does not stall; the
// classifier and rule logic lie between the input register and the result register.
// Reset (i_rst_n low at a clock edge): both stage valid bits drop and the
// running context (previous class, RI parity, emoji chain) returns to the
// start-of-text state; the first item after reset always breaks.
// When the receiver stalls, the result register holds its item; the input
// register still takes one more item, and o_stall rises once both stages are
// full. Context advances only as an item moves into the result register.
module grapheme_boundary_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [20:0] i_code_point,
    input  logic        i_text_begin,
    input  logic        i_bad_sequence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_boundary,
    output logic [3:0]  o_break_class
);

    // Input stage
    logic                     r_mid_valid;
    logic [gbd_pkg::CP_W-1:0] r_mid_cp;
    logic                     r_mid_begin;
    logic                     r_mid_bad;

    // Result stage
    logic                     r_out_valid;
    logic                     r_out_boundary;
    gbd_pkg::t_break_class    r_out_class;

    // Running context
    logic                     r_have_prev;
    gbd_pkg::t_break_class    r_prev_class;
    logic                     r_ri_odd;
    logic                     r_chain_open;
    logic                     r_zwj_after_emoji;

    logic                     n_have_prev;
    gbd_pkg::t_break_class    n_prev_class;
    logic                     n_ri_odd;
    logic                     n_chain_open;
    logic                     n_zwj_after_emoji;
    logic                     n_boundary;

    gbd_pkg::t_break_class    w_raw_class;
    gbd_pkg::t_break_class    w_class;
    logic                     w_linked;
    logic                     w_chain_before;
    logic                     w_out_ready;
    logic                     w_mid_ready;
    logic                     w_in_fire;
    logic                     w_mid_fire;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_mid_ready = !r_mid_valid || w_out_ready;
    assign w_in_fire   = i_valid && w_mid_ready;
    assign w_mid_fire  = r_mid_valid && w_out_ready;
    assign o_stall     = !w_mid_ready;

    gbd_classify u_classify (
        .i_code_point (r_mid_cp),
        .o_class      (w_raw_class)
    );

    function automatic logic rule_break(
        input gbd_pkg::t_break_class a,
        input gbd_pkg::t_break_class b,
        input logic                  joiner_ok,
        input logic                  ri_odd
    );
        logic a_ctl;
        logic b_ctl;
        logic brk;
        a_ctl = (a == gbd_pkg::CLS_CR) || (a == gbd_pkg::CLS_LF) ||
                (a == gbd_pkg::CLS_CONTROL);
        b_ctl = (b == gbd_pkg::CLS_CR) || (b == gbd_pkg::CLS_LF) ||
                (b == gbd_pkg::CLS_CONTROL);
        if ((a == gbd_pkg::CLS_CR) && (b == gbd_pkg::CLS_LF)) begin
            brk = 1'b0;
        end else if (a_ctl || b_ctl) begin
            brk = 1'b1;
        end else if ((a == gbd_pkg::CLS_L) &&
                     ((b == gbd_pkg::CLS_L) || (b == gbd_pkg::CLS_V) ||
                      (b == gbd_pkg::CLS_LV) || (b == gbd_pkg::CLS_LVT))) begin
            brk = 1'b0;
        end else if (((a == gbd_pkg::CLS_LV) || (a == gbd_pkg::CLS_V)) &&
                     ((b == gbd_pkg::CLS_V) || (b == gbd_pkg::CLS_T))) begin
            brk = 1'b0;
        end else if (((a == gbd_pkg::CLS_LVT) || (a == gbd_pkg::CLS_T)) &&
                     (b == gbd_pkg::CLS_T)) begin
            brk = 1'b0;
        end else if ((b == gbd_pkg::CLS_EXTEND) || (b == gbd_pkg::CLS_ZWJ) ||
                     (b == gbd_pkg::CLS_SPACING)) begin
            brk = 1'b0;
        end else if (a == gbd_pkg::CLS_PREPEND) begin
            brk = 1'b0;
        end else if ((a == gbd_pkg::CLS_ZWJ) && joiner_ok && (b == gbd_pkg::CLS_PICT)) begin
            brk = 1'b0;
        end else if ((a == gbd_pkg::CLS_RI) && (b == gbd_pkg::CLS_RI)) begin
            brk = !ri_odd;
        end else begin
            brk = 1'b1;
        end
        return brk;
    endfunction

    always_comb begin
        w_linked       = r_have_prev && !r_mid_begin;
        w_class        = r_mid_bad ? gbd_pkg::CLS_OTHER : w_raw_class;
        w_chain_before = w_linked && r_chain_open;

        if (!w_linked || r_mid_bad) begin
            n_boundary = 1'b1;
        end else begin
            n_boundary = rule_break(r_prev_class, w_class, r_zwj_after_emoji, r_ri_odd);
        end

        if (w_class == gbd_pkg::CLS_RI) begin
            n_ri_odd = (w_linked && (r_prev_class == gbd_pkg::CLS_RI)) ? !r_ri_odd : 1'b1;
        end else begin
            n_ri_odd = 1'b0;
        end
        n_zwj_after_emoji = (w_class == gbd_pkg::CLS_ZWJ) && w_chain_before;
        n_chain_open      = (w_class == gbd_pkg::CLS_PICT) ||
                            ((w_class == gbd_pkg::CLS_EXTEND) && w_chain_before);
        n_prev_class      = w_class;
        n_have_prev       = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid       <= 1'b0;
            r_out_valid       <= 1'b0;
            r_have_prev       <= 1'b0;
            r_prev_class      <= gbd_pkg::CLS_OTHER;
            r_ri_odd          <= 1'b0;
            r_chain_open      <= 1'b0;
            r_zwj_after_emoji <= 1'b0;
        end else begin
            if (w_mid_ready) begin
                r_mid_valid <= i_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_mid_valid;
            end
            // Advance context only as an item leaves the input stage.
            if (w_mid_fire) begin
                r_have_prev       <= n_have_prev;
                r_prev_class      <= n_prev_class;
                r_ri_odd          <= n_ri_odd;
                r_chain_open      <= n_chain_open;
                r_zwj_after_emoji <= n_zwj_after_emoji;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mid_cp    <= i_code_point;
            r_mid_begin <= i_text_begin;
            r_mid_bad   <= i_bad_sequence;
        end
        if (w_mid_fire) begin
            r_out_boundary <= n_boundary;
            r_out_class    <= w_class;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_boundary    = r_out_boundary;
    assign o_break_class = r_out_class;

    a_ri_odd_after_ri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ri_odd |-> (r_prev_class == gbd_pkg::CLS_RI))
        else $error("RI parity set after a non-RI item");

    a_joiner_after_zwj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zwj_after_emoji |-> (r_prev_class == gbd_pkg::CLS_ZWJ))
        else $error("emoji joiner flag set after a non-ZWJ item");

    a_chain_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chain_open |-> ((r_prev_class == gbd_pkg::CLS_PICT) ||
                          (r_prev_class == gbd_pkg::CLS_EXTEND)))
        else $error("emoji chain open after wrong class");

    a_clean_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_prev |-> (!r_ri_odd && !r_chain_open && !r_zwj_after_emoji))
        else $error("context flags set before any item");

    a_first_breaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_fire && (!r_have_prev || r_mid_begin || r_mid_bad))
            |=> (o_valid && o_boundary))
        else $error("forced boundary missing");

endmodule
